// ----- hw/rtl/mbs_pkg.sv -----
// Shared types and constants for the mesh background subtractor.
// No dependencies; every other file but mbs_ram imports this package.
`timescale 1ns / 1ps

package mbs_pkg;

  localparam int unsigned GRID_COLS_MAX = 64;
  localparam int unsigned GRID_ROWS_MAX = 64;
  localparam int unsigned IMAGE_DIM_MAX = 8192;

  localparam int unsigned DIM_W     = 14;   // image and cell size registers
  localparam int unsigned COORD_W   = 13;   // pixel column or row
  localparam int unsigned GRID_W    = 7;    // grid count registers
  localparam int unsigned NM1_W     = 6;    // grid count minus one after clamping
  localparam int unsigned SPAN_W    = 13;   // positive span of one axis
  localparam int unsigned FRAC_W    = 16;   // fraction bits of a grid position
  localparam int unsigned POS_W     = 24;   // grid position, Q16
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned TAB_AW    = 12;
  localparam int unsigned TAB_DEPTH = 4096;
  localparam int unsigned IDX_W     = 6;    // grid cell index
  localparam int unsigned WGT_W     = 25;   // signed Q16 blend weight

  // position divider: one quotient bit per stage, plus two set-up stages and
  // the output select stage
  localparam int unsigned DIV_STEPS = POS_W;
  localparam int unsigned AXIS_LAT  = DIV_STEPS + 3;

  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_GRID_COLUMNS = 3'd2;
  localparam logic [2:0] REG_GRID_ROWS    = 3'd3;
  localparam logic [2:0] REG_CELL_WIDTH   = 3'd4;
  localparam logic [2:0] REG_CELL_HEIGHT  = 3'd5;
  localparam logic [2:0] REG_BLANK_VALUE  = 3'd6;

  // per-axis constants worked out from the configuration registers
  typedef struct packed {
    logic                    zero;   // position is always 0 on this axis
    logic [COORD_W-1:0]      half;   // cell size / 2
    logic signed [DIM_W:0]   top;    // size - half
    logic [SPAN_W-1:0]       span;   // size - cell, valid when not zero
    logic [NM1_W-1:0]        nm1;    // grid count - 1
  } axis_cfg_t;

  // what travels beside the arithmetic through every stage
  typedef struct packed {
    logic              valid;
    logic              load;
    logic              blank;
    logic [DATA_W-1:0] pixel;
    logic [TAB_AW-1:0] gidx;
    logic [DATA_W-1:0] gval;
  } ctl_t;

endpackage

// ----- hw/rtl/mesh_background_subtract_top.sv -----
// Top level of the mesh background subtractor: APB registers, pixel pipeline,
// grid table. Depends on mbs_pkg, mbs_axis and mbs_ram.
`timescale 1ns / 1ps

// Streams words through a 36-stage pipeline at one word per clock: each word
// is either a grid load (in_tuser low) that writes one background entry, or a
// pixel (in_tuser high) that leaves as pixel minus the bilinearly
// interpolated background. Most of the depth lies in the per-axis position
// mapper, whose 24-step pipelined divider sets the depth. The whole pipeline
// holds while out_tready is low and a result is waiting, and moves on
// otherwise, so a stall loses nothing.
// The 4096-entry table is kept in four identical RAM copies so that the four
// corners of a cell are read in one cycle; loads write all copies. Entries
// read before they are loaded return whatever the RAM holds: there is no
// clearing pass. Load the grid before the first pixel, and write registers
// only while no word is in flight.
module mesh_background_subtract_top (
  input  logic         clk,
  input  logic         rst_n,

  input  logic         in_tvalid,
  output logic         in_tready,
  // [11:0] grid_index, [43:12] grid_value, [75:44] pixel_in,
  // [88:76] column, [101:89] row, [103:102] zero
  input  logic [103:0] in_tdata,
  // [0] action
  input  logic         in_tuser,

  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] pixel_out, [63:32] background
  output logic [63:0]  out_tdata,
  // [0] was_blank
  output logic         out_tuser,

  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import mbs_pkg::*;

  localparam int unsigned PROD_W = WGT_W + DATA_W;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam int unsigned R_W    = SUM_W - FRAC_W;
  localparam int unsigned LO_W   = 21;
  localparam int unsigned PP_W   = WGT_W + LO_W + 1;
  localparam int unsigned ACC_W  = WGT_W + R_W + 1;
  localparam int unsigned RND_W  = ACC_W - FRAC_W;
  localparam logic signed [WGT_W-1:0] ONE_Q16 = WGT_W'(65536);
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // ---------------------------------------------------------------- registers
  logic [DIM_W-1:0]  image_width_r, image_height_r, cell_width_r, cell_height_r;
  logic [GRID_W-1:0] grid_columns_r, grid_rows_r;
  logic [DATA_W-1:0] blank_value_r;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= DIM_W'(2048);
      image_height_r <= DIM_W'(4096);
      grid_columns_r <= GRID_W'(1);
      grid_rows_r    <= GRID_W'(1);
      cell_width_r   <= DIM_W'(100);
      cell_height_r  <= DIM_W'(100);
      blank_value_r  <= 32'h8000_0000;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:2])
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height_r <= cfg_pwdata[DIM_W-1:0];
        REG_GRID_COLUMNS: grid_columns_r <= cfg_pwdata[GRID_W-1:0];
        REG_GRID_ROWS:    grid_rows_r    <= cfg_pwdata[GRID_W-1:0];
        REG_CELL_WIDTH:   cell_width_r   <= cfg_pwdata[DIM_W-1:0];
        REG_CELL_HEIGHT:  cell_height_r  <= cfg_pwdata[DIM_W-1:0];
        REG_BLANK_VALUE:  blank_value_r  <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:2])
      REG_IMAGE_WIDTH:  cfg_prdata = 32'(image_width_r);
      REG_IMAGE_HEIGHT: cfg_prdata = 32'(image_height_r);
      REG_GRID_COLUMNS: cfg_prdata = 32'(grid_columns_r);
      REG_GRID_ROWS:    cfg_prdata = 32'(grid_rows_r);
      REG_CELL_WIDTH:   cfg_prdata = 32'(cell_width_r);
      REG_CELL_HEIGHT:  cfg_prdata = 32'(cell_height_r);
      REG_BLANK_VALUE:  cfg_prdata = blank_value_r;
      default:          cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------- constants derived from setup
  // Clamp sizes to their maxima and register half cell, span and the edge limit;
  // the user must change them only while the pipeline is empty: the block does not enforce it.
  function automatic axis_cfg_t axis_setup(input logic [DIM_W-1:0]  size_raw,
                                           input logic [DIM_W-1:0]  cell_raw,
                                           input logic [GRID_W-1:0] n);
    logic [DIM_W-1:0]      s;
    logic [DIM_W-1:0]      c;
    logic signed [DIM_W:0] span_s;
    axis_cfg_t             a;
    s      = (size_raw > DIM_W'(IMAGE_DIM_MAX)) ? DIM_W'(IMAGE_DIM_MAX) : size_raw;
    c      = (cell_raw > DIM_W'(IMAGE_DIM_MAX)) ? DIM_W'(IMAGE_DIM_MAX) : cell_raw;
    span_s = $signed({1'b0, s}) - $signed({1'b0, c});
    a.half = c[DIM_W-1:1];
    a.top  = $signed({1'b0, s}) - $signed({2'b00, a.half});
    a.span = span_s[SPAN_W-1:0];
    a.nm1  = NM1_W'(n - GRID_W'(1));
    a.zero = (n <= GRID_W'(1)) || (span_s <= 0);
    return a;
  endfunction

  logic [GRID_W-1:0] nx_c, ny_c, nx_r, ny_r;
  axis_cfg_t         xcfg_r, ycfg_r;
  logic              zero_grid_r;

  assign nx_c = (grid_columns_r > GRID_W'(GRID_COLS_MAX)) ? GRID_W'(GRID_COLS_MAX)
                                                           : grid_columns_r;
  assign ny_c = (grid_rows_r > GRID_W'(GRID_ROWS_MAX)) ? GRID_W'(GRID_ROWS_MAX)
                                                        : grid_rows_r;

  always_ff @(posedge clk) begin
    nx_r        <= nx_c;
    ny_r        <= ny_c;
    xcfg_r      <= axis_setup(image_width_r, cell_width_r, nx_c);
    ycfg_r      <= axis_setup(image_height_r, cell_height_r, ny_c);
    zero_grid_r <= (nx_c == '0) || (ny_c == '0);
  end

  // ------------------------------------------------------------ flow control
  // One enable for the whole pipeline: advance unless a result is waiting and out_tready is low.
  logic adv;
  logic out_valid_r, out_blank_r;
  logic [DATA_W-1:0] out_pix_r, out_bg_r;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  // ------------------------------------------------------------ input stage
  ctl_t               ctl_in, ctl_p1_r;
  logic [COORD_W-1:0] col_p1_r, row_p1_r;

  always_comb begin
    ctl_in.valid = in_tvalid;
    ctl_in.load  = !in_tuser;
    ctl_in.pixel = in_tdata[75:44];
    ctl_in.blank = in_tdata[75:44] == blank_value_r;
    ctl_in.gidx  = in_tdata[11:0];
    ctl_in.gval  = in_tdata[43:12];
  end

  // ------------------------------------------------------- position mappers
  logic [POS_W-1:0] pos_x, pos_y;

  mbs_axis u_axis_x (
    .clk   (clk),
    .adv   (adv),
    .cfg   (xcfg_r),
    .coord (col_p1_r),
    .pos   (pos_x)
  );

  mbs_axis u_axis_y (
    .clk   (clk),
    .adv   (adv),
    .cfg   (ycfg_r),
    .coord (row_p1_r),
    .pos   (pos_y)
  );

  // hold the word's side data level with the mappers
  ctl_t ctl_d_r [AXIS_LAT];

  // ------------------------------------------------ cell index and weights
  function automatic logic [IDX_W-1:0] cell_idx(input logic [POS_W-1:0]  p,
                                                input logic [GRID_W-1:0] n);
    logic [POS_W-FRAC_W-1:0] fl;
    fl = p[POS_W-1:FRAC_W];
    if (n < GRID_W'(2)) begin
      return '0;
    end else if (fl >= (POS_W - FRAC_W)'(n - GRID_W'(1))) begin
      return IDX_W'(n - GRID_W'(2));
    end else begin
      return IDX_W'(fl);
    end
  endfunction

  logic [IDX_W-1:0]        i1_c, j1_c;
  logic signed [WGT_W-1:0] dx1_c, dy1_c;

  assign i1_c  = cell_idx(pos_x, nx_r);
  assign j1_c  = cell_idx(pos_y, ny_r);
  // a one-point axis takes the single entry at full weight
  assign dx1_c = (nx_r < GRID_W'(2)) ? ONE_Q16
               : WGT_W'({1'b0, pos_x}) - WGT_W'({i1_c, FRAC_W'(0)});
  assign dy1_c = (ny_r < GRID_W'(2)) ? ONE_Q16
               : WGT_W'({1'b0, pos_y}) - WGT_W'({j1_c, FRAC_W'(0)});

  ctl_t                    ctl_t1_r, ctl_t2_r, ctl_t3_r, ctl_t4_r;
  ctl_t                    ctl_t5_r, ctl_t6_r, ctl_t7_r;
  logic [IDX_W-1:0]        i1_t1_r, j1_t1_r;
  logic                    onex_t1_r, oney_t1_r;
  logic signed [WGT_W-1:0] dx1_t1_r, dx2_t1_r, dy1_t1_r, dy2_t1_r;

  // ------------------------------------------------------- table addresses
  localparam int unsigned BASE_W = GRID_W + IDX_W;
  logic [IDX_W-1:0]  i2_c, j2_c;
  logic [BASE_W-1:0] base1_c, base2_c;
  logic [TAB_AW-1:0] addr_c [4];

  assign i2_c    = onex_t1_r ? i1_t1_r : i1_t1_r + IDX_W'(1);
  assign j2_c    = oney_t1_r ? j1_t1_r : j1_t1_r + IDX_W'(1);
  assign base1_c = BASE_W'(nx_r) * BASE_W'(j1_t1_r);
  assign base2_c = BASE_W'(nx_r) * BASE_W'(j2_c);

  always_comb begin
    addr_c[0] = TAB_AW'(base1_c + BASE_W'(i1_t1_r));
    addr_c[1] = TAB_AW'(base1_c + BASE_W'(i2_c));
    addr_c[2] = TAB_AW'(base2_c + BASE_W'(i1_t1_r));
    addr_c[3] = TAB_AW'(base2_c + BASE_W'(i2_c));
  end

  logic [TAB_AW-1:0]       addr_t2_r [4];
  logic signed [WGT_W-1:0] dx1_t2_r, dx2_t2_r, dy1_t2_r, dy2_t2_r;

  // ------------------------------------------------------------ grid table
  logic [DATA_W-1:0] tab_q [4];
  logic              tab_we;

  assign tab_we = adv && ctl_t2_r.valid && ctl_t2_r.load;

  for (genvar g = 0; g < 4; g++) begin : g_tab
    mbs_ram #(
      .WIDTH (DATA_W),
      .DEPTH (TAB_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (tab_we),
      .waddr (ctl_t2_r.gidx),
      .wdata (ctl_t2_r.gval),
      .re    (adv),
      .raddr (addr_t2_r[g]),
      .rdata (tab_q[g])
    );
  end

  logic signed [WGT_W-1:0] dx1_t3_r, dx2_t3_r, dy1_t3_r, dy2_t3_r;

  // ------------------------------------------------------ blend along rows
  logic signed [PROD_W-1:0] prod_c [4];
  logic signed [PROD_W-1:0] prod_t4_r [4];
  logic signed [WGT_W-1:0]  dy1_t4_r, dy2_t4_r;

  always_comb begin
    prod_c[0] = dx2_t3_r * $signed(tab_q[0]);
    prod_c[1] = dx1_t3_r * $signed(tab_q[1]);
    prod_c[2] = dx2_t3_r * $signed(tab_q[2]);
    prod_c[3] = dx1_t3_r * $signed(tab_q[3]);
  end

  // round Q16 to Q0, half up
  logic signed [SUM_W-1:0] sum1_c, sum2_c;
  logic signed [R_W-1:0]   r_t5_r [2];
  logic signed [WGT_W-1:0] dy1_t5_r, dy2_t5_r;

  assign sum1_c = SUM_W'(prod_t4_r[0]) + SUM_W'(prod_t4_r[1]) + SUM_W'(32768);
  assign sum2_c = SUM_W'(prod_t4_r[2]) + SUM_W'(prod_t4_r[3]) + SUM_W'(32768);

  // ------------------------------------------------- blend along columns
  // each row result is split in two halves to keep the multipliers narrow
  logic signed [PP_W-1:0] pp_c [4];
  logic signed [PP_W-1:0] pp_t6_r [4];

  always_comb begin
    pp_c[0] = dy2_t5_r * $signed({1'b0, r_t5_r[0][LO_W-1:0]});
    pp_c[1] = dy2_t5_r * $signed(r_t5_r[0][R_W-1:LO_W]);
    pp_c[2] = dy1_t5_r * $signed({1'b0, r_t5_r[1][LO_W-1:0]});
    pp_c[3] = dy1_t5_r * $signed(r_t5_r[1][R_W-1:LO_W]);
  end

  logic signed [ACC_W-1:0] acc_c;
  logic signed [RND_W-1:0] rnd_c;
  logic [DATA_W-1:0]       bg_c, bg_t7_r;

  assign acc_c = (ACC_W'(pp_t6_r[1]) <<< LO_W) + ACC_W'(pp_t6_r[0])
               + (ACC_W'(pp_t6_r[3]) <<< LO_W) + ACC_W'(pp_t6_r[2])
               + ACC_W'(32768);
  assign rnd_c = RND_W'(acc_c >>> FRAC_W);

  always_comb begin
    if (zero_grid_r || ctl_t6_r.blank) begin
      bg_c = '0;
    end else if (rnd_c > RND_W'(S32_MAX)) begin
      bg_c = S32_MAX;
    end else if (rnd_c < RND_W'(S32_MIN)) begin
      bg_c = S32_MIN;
    end else begin
      bg_c = rnd_c[DATA_W-1:0];
    end
  end

  // ------------------------------------------------------------ subtract
  logic signed [DATA_W:0] diff_c;
  logic [DATA_W-1:0]      pix_out_c;

  assign diff_c = $signed({ctl_t7_r.pixel[DATA_W-1], ctl_t7_r.pixel})
                - $signed({bg_t7_r[DATA_W-1], bg_t7_r});

  always_comb begin
    if (diff_c > (DATA_W + 1)'(S32_MAX)) begin
      pix_out_c = S32_MAX;
    end else if (diff_c < (DATA_W + 1)'(S32_MIN)) begin
      pix_out_c = S32_MIN;
    end else begin
      pix_out_c = diff_c[DATA_W-1:0];
    end
  end

  // --------------------------------------------------------- control path
  // Valid bits and side data; reset drops every word in flight.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_p1_r    <= '0;
      for (int k = 0; k < AXIS_LAT; k++) begin
        ctl_d_r[k] <= '0;
      end
      ctl_t1_r    <= '0;
      ctl_t2_r    <= '0;
      ctl_t3_r    <= '0;
      ctl_t4_r    <= '0;
      ctl_t5_r    <= '0;
      ctl_t6_r    <= '0;
      ctl_t7_r    <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      ctl_p1_r   <= ctl_in;
      ctl_d_r[0] <= ctl_p1_r;
      for (int k = 1; k < AXIS_LAT; k++) begin
        ctl_d_r[k] <= ctl_d_r[k-1];
      end
      ctl_t1_r    <= ctl_d_r[AXIS_LAT-1];
      ctl_t2_r    <= ctl_t1_r;
      ctl_t3_r    <= ctl_t2_r;
      ctl_t4_r    <= ctl_t3_r;
      ctl_t5_r    <= ctl_t4_r;
      ctl_t6_r    <= ctl_t5_r;
      ctl_t7_r    <= ctl_t6_r;
      out_valid_r <= ctl_t7_r.valid && !ctl_t7_r.load;
    end
  end

  // ------------------------------------------------------------ data path
  always_ff @(posedge clk) begin
    if (adv) begin
      col_p1_r  <= in_tdata[88:76];
      row_p1_r  <= in_tdata[101:89];

      i1_t1_r   <= i1_c;
      j1_t1_r   <= j1_c;
      onex_t1_r <= nx_r < GRID_W'(2);
      oney_t1_r <= ny_r < GRID_W'(2);
      dx1_t1_r  <= dx1_c;
      dx2_t1_r  <= ONE_Q16 - dx1_c;
      dy1_t1_r  <= dy1_c;
      dy2_t1_r  <= ONE_Q16 - dy1_c;

      for (int k = 0; k < 4; k++) begin
        addr_t2_r[k] <= addr_c[k];
        prod_t4_r[k] <= prod_c[k];
        pp_t6_r[k]   <= pp_c[k];
      end
      dx1_t2_r <= dx1_t1_r;
      dx2_t2_r <= dx2_t1_r;
      dy1_t2_r <= dy1_t1_r;
      dy2_t2_r <= dy2_t1_r;
      dx1_t3_r <= dx1_t2_r;
      dx2_t3_r <= dx2_t2_r;
      dy1_t3_r <= dy1_t2_r;
      dy2_t3_r <= dy2_t2_r;
      dy1_t4_r <= dy1_t3_r;
      dy2_t4_r <= dy2_t3_r;
      dy1_t5_r <= dy1_t4_r;
      dy2_t5_r <= dy2_t4_r;

      r_t5_r[0] <= R_W'(sum1_c >>> FRAC_W);
      r_t5_r[1] <= R_W'(sum2_c >>> FRAC_W);

      bg_t7_r <= bg_c;

      // a blank pixel meets a zero background, so the difference is the pixel
      out_pix_r   <= pix_out_c;
      out_bg_r    <= bg_t7_r;
      out_blank_r <= ctl_t7_r.blank;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_bg_r, out_pix_r};
  assign out_tuser  = out_blank_r;

  // ------------------------------------------------------------ assertions
  a_blank_no_bg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_blank_r |-> out_bg_r == '0)
    else $error("blank pixel carries a non-zero background");

  a_blank_raw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_blank_r |-> out_pix_r == blank_value_r)
    else $error("blank pixel not passed through unchanged");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    adv && ctl_t7_r.valid && ctl_t7_r.load |=> !out_valid_r)
    else $error("grid load produced a result word");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result word valid straight after reset");

endmodule

// ----- hw/rtl/mbs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/mbs_axis.sv -----
// One axis of the position mapper: pixel coordinate to Q16 grid position.
// Depends on mbs_pkg; holds a pipelined restoring divider, one bit a stage.
`timescale 1ns / 1ps

module mbs_axis (
  input  logic                      clk,
  input  logic                      adv,
  input  mbs_pkg::axis_cfg_t        cfg,
  input  logic [mbs_pkg::COORD_W-1:0] coord,
  output logic [mbs_pkg::POS_W-1:0]   pos
);
  import mbs_pkg::*;

  typedef enum logic [1:0] {POS_ZERO, POS_DIV, POS_TOP} pos_sel_t;

  localparam int unsigned PROD_W  = COORD_W + NM1_W;
  localparam int unsigned DVD_W   = PROD_W + FRAC_W + 1;
  localparam int unsigned DIV_W   = SPAN_W + 1;
  localparam int unsigned REM_W   = DIV_W;
  localparam int unsigned TRIAL_W = REM_W + 1;

  pos_sel_t           sel1_r, sel2_r;
  logic [COORD_W-1:0] off1_r;
  logic [DVD_W-1:0]   dvd2_r;
  logic [POS_W-1:0]   pos_r;

  pos_sel_t           seld_r   [DIV_STEPS];
  logic [REM_W-1:0]   rem_r    [DIV_STEPS];
  logic [POS_W-1:0]   work_r   [DIV_STEPS];

  pos_sel_t           sin      [DIV_STEPS];
  logic [REM_W-1:0]   rin      [DIV_STEPS];
  logic [POS_W-1:0]   win      [DIV_STEPS];
  logic [TRIAL_W-1:0] trial    [DIV_STEPS];
  logic               ge       [DIV_STEPS];
  logic [REM_W-1:0]   rem_nxt  [DIV_STEPS];
  logic [POS_W-1:0]   work_nxt [DIV_STEPS];

  pos_sel_t           sel1_nxt;
  logic [PROD_W-1:0]  prod;
  logic [DVD_W-1:0]   dvd2_nxt;
  logic [DIV_W-1:0]   divisor;
  logic [POS_W-1:0]   pos_nxt;

  // classify the coordinate against the edge bands
  always_comb begin
    if (cfg.zero || coord < cfg.half) begin
      sel1_nxt = POS_ZERO;
    end else if ($signed({2'b00, coord}) > cfg.top) begin
      sel1_nxt = POS_TOP;
    end else begin
      sel1_nxt = POS_DIV;
    end
  end

  // dividend is 2*(c-half)*(n-1)*2^16 + span, divisor 2*span: rounds half up
  assign prod     = PROD_W'(off1_r) * PROD_W'(cfg.nm1);
  assign dvd2_nxt = {prod, (FRAC_W + 1)'(0)} | DVD_W'(cfg.span);
  assign divisor  = {cfg.span, 1'b0};

  always_comb begin
    rin[0] = REM_W'(dvd2_r[DVD_W-1:POS_W]);
    win[0] = dvd2_r[POS_W-1:0];
    sin[0] = sel2_r;
    for (int k = 1; k < DIV_STEPS; k++) begin
      rin[k] = rem_r[k-1];
      win[k] = work_r[k-1];
      sin[k] = seld_r[k-1];
    end
  end

  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial[k]    = {rin[k], win[k][POS_W-1]};
      ge[k]       = trial[k] >= TRIAL_W'(divisor);
      rem_nxt[k]  = ge[k] ? REM_W'(trial[k] - TRIAL_W'(divisor)) : REM_W'(trial[k]);
      work_nxt[k] = {win[k][POS_W-2:0], ge[k]};
    end
  end

  always_comb begin
    case (seld_r[DIV_STEPS-1])
      POS_DIV: pos_nxt = work_r[DIV_STEPS-1];
      POS_TOP: pos_nxt = POS_W'({cfg.nm1, FRAC_W'(0)});
      default: pos_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sel1_r <= sel1_nxt;
      off1_r <= coord - cfg.half;
      sel2_r <= sel1_r;
      dvd2_r <= dvd2_nxt;
      for (int k = 0; k < DIV_STEPS; k++) begin
        seld_r[k] <= sin[k];
        rem_r[k]  <= rem_nxt[k];
        work_r[k] <= work_nxt[k];
      end
      pos_r <= pos_nxt;
    end
  end

  assign pos = pos_r;

endmodule

// ----- test/mbs_checker.sv -----
// Checker for the mesh background subtractor: tracks registers and grid loads,
// predicts each pixel result and compares it with the output channel.
// Depends on mbs_pkg for register codes, table depth and size limits.
`timescale 1ns / 1ps

module mbs_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [103:0] in_tdata,
  input  logic         in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [63:0]  out_tdata,
  input  logic         out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  input  logic         cfg_pready,
  output int           fails,
  output int           pending
);
  import mbs_pkg::*;

  typedef struct {
    logic [31:0] pixel_out;
    logic [31:0] background;
    logic        was_blank;
  } sub_result_t;

  logic [13:0] img_w, img_h, cel_w, cel_h;
  logic [6:0]  g_cols, g_rows;
  logic [31:0] blank_word;
  logic [31:0] grid_copy [TAB_DEPTH];
  sub_result_t want_q [$];

  function automatic longint round_q16(longint v);
    v += 32768;
    if (v >= 0) return v / 65536;
    return -((-v + 65535) / 65536);
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint cap(longint v, longint mx);
    return (v > mx) ? mx : v;
  endfunction

  function automatic longint map_axis(longint c, longint size, longint cell_sz, longint n);
    longint half, span;
    half = cell_sz / 2;
    span = size - cell_sz;
    if (n <= 1 || span <= 0) return 0;
    if (c < half) return 0;
    if (c > size - half) return (n - 1) * 65536;
    return (((c - half) * (n - 1) * 65536) * 2 + span) / (2 * span);
  endfunction

  function automatic longint grid_at(longint i, longint j, longint ncols);
    logic [11:0] a;
    a = 12'(i + ncols * j);
    return longint'($signed(grid_copy[a]));
  endfunction

  function automatic longint blend_grid(longint px, longint py, longint nx, longint ny);
    longint i1, i2, j1, j2, dx1, dx2, dy1, dy2, r1, r2;
    if (nx < 1 || ny < 1) return 0;
    i1 = px / 65536;
    if (i1 >= nx - 1) i1 = nx - 2;
    if (i1 < 0) i1 = 0;
    i2 = i1 + 1;
    j1 = py / 65536;
    if (j1 >= ny - 1) j1 = ny - 2;
    if (j1 < 0) j1 = 0;
    j2 = j1 + 1;
    dx1 = px - i1 * 65536;
    dy1 = py - j1 * 65536;
    dx2 = 65536 - dx1;
    dy2 = 65536 - dy1;
    if (i2 > nx - 1) begin
      i2 = i1; dx1 = 65536; dx2 = 0;
    end
    if (j2 > ny - 1) begin
      j2 = j1; dy1 = 65536; dy2 = 0;
    end
    r1 = round_q16(dx2 * grid_at(i1, j1, nx) + dx1 * grid_at(i2, j1, nx));
    r2 = round_q16(dx2 * grid_at(i1, j2, nx) + dx1 * grid_at(i2, j2, nx));
    return clip32(round_q16(dy2 * r1 + dy1 * r2));
  endfunction

  function automatic sub_result_t subtract_pixel(logic [31:0] pix, logic [12:0] col,
                                                 logic [12:0] row);
    sub_result_t r;
    longint nx, ny, px, py, bg;
    if (pix == blank_word) begin
      r.pixel_out = pix; r.background = '0; r.was_blank = 1'b1;
      return r;
    end
    nx = cap(g_cols, GRID_COLS_MAX);
    ny = cap(g_rows, GRID_ROWS_MAX);
    px = map_axis(col, cap(img_w, IMAGE_DIM_MAX), cap(cel_w, IMAGE_DIM_MAX), nx);
    py = map_axis(row, cap(img_h, IMAGE_DIM_MAX), cap(cel_h, IMAGE_DIM_MAX), ny);
    bg = blend_grid(px, py, nx, ny);
    r.pixel_out  = 32'(clip32(longint'($signed(pix)) - bg));
    r.background = 32'(bg);
    r.was_blank  = 1'b0;
    return r;
  endfunction

  // Sample at the falling edge: everything driven at the rising edge is settled.
  always @(negedge clk) begin
    sub_result_t got, want;
    int bad;
    if (!rst_n) begin
      img_w <= 14'd2048; img_h <= 14'd4096;
      g_cols <= 7'd1; g_rows <= 7'd1;
      cel_w <= 14'd100; cel_h <= 14'd100;
      blank_word <= 32'h8000_0000;
      fails <= 0;
      pending <= 0;
    end else begin
      bad = 0;
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          REG_IMAGE_WIDTH:  img_w <= cfg_pwdata[13:0];
          REG_IMAGE_HEIGHT: img_h <= cfg_pwdata[13:0];
          REG_GRID_COLUMNS: g_cols <= cfg_pwdata[6:0];
          REG_GRID_ROWS:    g_rows <= cfg_pwdata[6:0];
          REG_CELL_WIDTH:   cel_w <= cfg_pwdata[13:0];
          REG_CELL_HEIGHT:  cel_h <= cfg_pwdata[13:0];
          REG_BLANK_VALUE:  blank_word <= cfg_pwdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (!in_tuser) grid_copy[in_tdata[11:0]] = in_tdata[43:12];
        else want_q.push_back(subtract_pixel(in_tdata[75:44], in_tdata[88:76],
                                             in_tdata[101:89]));
      end
      if (out_tvalid && out_tready) begin
        got.pixel_out = out_tdata[31:0];
        got.background = out_tdata[63:32];
        got.was_blank = out_tuser;
        if (want_q.size() == 0) begin
          $error("unexpected result word: pixel_out %h", got.pixel_out);
          bad++;
        end else begin
          want = want_q.pop_front();
          if (got.pixel_out !== want.pixel_out) begin
            $error("pixel_out: expected %h, got %h", want.pixel_out, got.pixel_out);
            bad++;
          end
          if (got.background !== want.background) begin
            $error("background: expected %h, got %h", want.background, got.background);
            bad++;
          end
          if (got.was_blank !== want.was_blank) begin
            $error("was_blank: expected %b, got %b", want.was_blank, got.was_blank);
            bad++;
          end
        end
      end
      fails <= fails + bad;
      pending <= want_q.size();
    end
  end

endmodule

// ----- test/tb_mesh_background_subtract_top.sv -----
// Testbench top for the mesh background subtractor: clock, reset, register
// writes, grid loads and pixel stimulus, verdict. Depends on mbs_pkg,
// mbs_checker and the block's RTL.
`timescale 1ns / 1ps

module tb_mesh_background_subtract_top;
  import mbs_pkg::*;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  // [11:0] grid_index, [43:12] grid_value, [75:44] pixel_in,
  // [88:76] column, [101:89] row, [103:102] zero
  logic [103:0] in_tdata = '0;
  // [0] action
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // [31:0] pixel_out, [63:32] background
  logic [63:0]  out_tdata;
  // [0] was_blank
  logic         out_tuser;
  logic         cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [4:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  int fails, pending;
  int tx_idle_pct = 0, rx_idle_pct = 0;
  int pixel_words = 0, load_words = 0, phases = 0;
  int quiet_cycles = 0;

  localparam int QUIET_LIMIT = 20000;

  always #10 clk = ~clk;

  mesh_background_subtract_top i_dut (.*);

  mbs_checker i_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .fails, .pending
  );

  // Receiver: stall at the rate of the current idling mode.
  always @(posedge clk) out_tready <= ($urandom_range(99) >= rx_idle_pct);

  // Watchdog: count cycles in which no word moves on any port.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    logic rdy;
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do begin
      @(negedge clk); rdy = cfg_pready;
      @(posedge clk);
    end while (!rdy);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Send one word; idle first at the sender's rate, then hold until taken.
  task automatic send_word(logic act, logic [11:0] gi, logic [31:0] gv,
                           logic [31:0] pix, logic [12:0] col, logic [12:0] row);
    logic rdy;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {2'b00, row, col, pix, gv, gi};
    do begin
      @(negedge clk); rdy = in_tready;
      @(posedge clk);
    end while (!rdy);
    if (act) pixel_words++; else load_words++;
  endtask

  function automatic logic [31:0] pick_value(logic [31:0] blank);
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h8000_0001;
      3: return blank;
      4, 5: return $urandom;
      default: return 32'($signed($urandom_range(200000)) - 100000);
    endcase
  endfunction

  // Wait for the pipeline to drain; loads leave no result, so pause beyond it.
  task automatic drain;
    while (pending != 0) @(posedge clk);
    repeat (AXIS_LAT + 20) @(posedge clk);
  endtask

  task automatic run_phase(int w, int h, int gc, int gr, int cw, int ch,
                           logic [31:0] blank, int npix, bit wr);
    int nx, ny, cmax, rmax;
    logic [12:0] col, row;
    in_tvalid <= 1'b0;
    drain();
    if (wr) begin
      reg_write(REG_IMAGE_WIDTH, w);
      reg_write(REG_IMAGE_HEIGHT, h);
      reg_write(REG_GRID_COLUMNS, gc);
      reg_write(REG_GRID_ROWS, gr);
      reg_write(REG_CELL_WIDTH, cw);
      reg_write(REG_CELL_HEIGHT, ch);
      reg_write(REG_BLANK_VALUE, blank);
    end
    phases++;
    nx = (gc > 64) ? 64 : gc;
    ny = (gr > 64) ? 64 : gr;
    // stray loads anywhere in the table, then the full grid over them
    repeat (3) send_word(1'b0, 12'($urandom), $urandom, $urandom, 13'($urandom),
                         13'($urandom));
    for (int k = 0; k < nx * ny; k++)
      send_word(1'b0, 12'(k), pick_value(blank), $urandom, 13'($urandom),
                13'($urandom));
    cmax = (w > 8192 ? 8192 : w) - 1;
    rmax = (h > 8192 ? 8192 : h) - 1;
    for (int k = 0; k < npix; k++) begin
      case ($urandom_range(9))
        0: begin col = '0; row = 13'h1FFF; end
        1: begin col = 13'h1FFF; row = '0; end
        2, 3: begin col = 13'($urandom); row = 13'($urandom); end
        default: begin col = 13'($urandom_range(cmax)); row = 13'($urandom_range(rmax)); end
      endcase
      send_word(1'b1, 12'($urandom), $urandom, pick_value(blank), col, row);
    end
  endtask

  initial begin
    int gc, gr;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, tiny image with no grid, a 64-column grid
    // with a zero-span axis, then a one-point axis against a wide one.
    run_phase(2048, 4096, 1, 1, 100, 100, 32'h8000_0000, 5, 1'b0);
    run_phase(1, 1, 0, 0, 1, 1, 32'h7FFF_FFFF, 5, 1'b1);
    run_phase(8192, 8192, 64, 4, 1, 8192, 32'h0, 8, 1'b1);
    run_phase(16, 8192, 8, 1, 3, 5, 32'h1234_5678, 6, 1'b1);

    for (int p = 0; p < 12; p++) begin
      if (p < 4) begin tx_idle_pct = 9; rx_idle_pct = 70; end
      else if (p < 8) begin tx_idle_pct = 70; rx_idle_pct = 9; end
      else begin tx_idle_pct = 0; rx_idle_pct = 0; end
      gc = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(1, 8);
      gr = ($urandom_range(9) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 8);
      if (gc > 8 && gr > 8) gr = 2;
      run_phase($urandom_range(1, 8192), $urandom_range(1, 8192), gc, gr,
                ($urandom_range(3) == 0) ? $urandom_range(1, 8192) : $urandom_range(1, 600),
                ($urandom_range(3) == 0) ? $urandom_range(1, 8192) : $urandom_range(1, 600),
                $urandom, 60, 1'b1);
    end

    in_tvalid <= 1'b0;
    tx_idle_pct = 0; rx_idle_pct = 0;
    drain();
    $display("covered %0d phases: %0d pixel words and %0d grid loads", phases,
             pixel_words, load_words);
    if (fails == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
